FILE: hw/rtl/tbp_pkg.sv
// Shared types, constants and training functions for the tournament branch predictor.
// No dependencies; imported by tournament_branch_predictor.
`default_nettype none

package tbp_pkg;

    localparam int TABLE_ENTRIES = 1024;
    // floor(log2(TABLE_ENTRIES)); only the lowest 2^IDX_BITS entries are used
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES + 1) - 1;
    localparam int IDX_ENTRIES   = 1 << IDX_BITS;

    localparam int PC_BITS       = 32;
    localparam int COUNT_BITS    = 32;
    localparam int S_DATA_BITS   = 40;
    localparam int M_DATA_BITS   = 72;

    typedef logic [1:0]            ctr2_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // Chooser encodings
    localparam ctr2_t CH_STRONG_GLOBAL = 2'd0;
    localparam ctr2_t CH_WEAK_GLOBAL   = 2'd1;
    localparam ctr2_t CH_WEAK_LOCAL    = 2'd2;
    localparam ctr2_t CH_STRONG_LOCAL  = 2'd3;

    localparam ctr2_t CTR_MIN = 2'd0;
    localparam ctr2_t CTR_MAX = 2'd3;

    // 2-bit saturating counter: up on taken, down on not taken
    function automatic ctr2_t sat_train(input ctr2_t c, input logic t);
        ctr2_t r;
        r = c;
        if (t) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

    // Chooser update; only applied when local and global predictions differ
    function automatic ctr2_t chooser_train(input ctr2_t c, input logic local_right);
        ctr2_t r;
        if (local_right) begin
            r = (c == CH_STRONG_GLOBAL) ? CH_WEAK_GLOBAL : CH_STRONG_LOCAL;
        end else begin
            r = (c == CH_STRONG_LOCAL) ? CH_WEAK_LOCAL : CH_STRONG_GLOBAL;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tournament_branch_predictor.sv
// Tournament branch predictor: local, global and chooser tables with training.
// Depends on tbp_pkg.
`default_nettype none

// One resolved branch per cycle is accepted unless the result side stalls;
// its result word passes through the table read, then compute and write-back
// into the output register. The tables are single-write, single-read memories;
// a branch that trains an entry read by the very next branch is forwarded.
// After reset the three tables are cleared one entry per cycle, all IDX_ENTRIES
// entries (1024 in this build); s_tready stays low meanwhile.
module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,   // [31:0] branch_pc, [32] taken
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_BITS-1:0]      m_tdata    // [0] predicted_taken, [1] mispredicted,
                                                   // [33:2] branch_total, [65:34] miss_total
);

    // Clear sweep
    logic [IDX_BITS:0] clr_cnt_reg;
    logic              clr_active;

    // Front end
    idx_t  history_reg;
    logic  s_accept;
    idx_t  li_in;
    logic  taken_in;

    // Stage 1
    logic  p1_valid_reg;
    idx_t  p1_li_reg;
    idx_t  p1_gi_reg;
    logic  p1_taken_reg;
    logic  p1_adv;

    // Memory read data and forwarding
    ctr2_t local_rd_reg, global_rd_reg, chooser_rd_reg;
    logic  byp_li_reg, byp_gi_reg;
    ctr2_t byp_local_reg, byp_global_reg, byp_chooser_reg;

    ctr2_t lc, gc, ch;
    logic  lp, gp, pred, miss;
    ctr2_t lc_new, gc_new, ch_new;

    // Write port
    logic  mem_we;
    idx_t  wa_local, wa_global;
    ctr2_t wd_local, wd_global, wd_chooser;

    // Tables
    ctr2_t local_mem   [IDX_ENTRIES];
    ctr2_t global_mem  [IDX_ENTRIES];
    ctr2_t chooser_mem [IDX_ENTRIES];

    // Totals and output register
    count_t branch_count_reg, miss_count_reg;
    count_t branch_count_next, miss_count_next;
    logic   out_valid_reg;
    logic   out_pred_reg, out_miss_reg;

    assign clr_active = ~clr_cnt_reg[IDX_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clr_active) begin
            clr_cnt_reg <= clr_cnt_reg + (IDX_BITS+1)'(1);
        end
    end

    assign p1_adv   = p1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~clr_active & (~p1_valid_reg | p1_adv);
    assign s_accept = s_tvalid & s_tready;
    assign li_in    = s_tdata[IDX_BITS+1:2];
    assign taken_in = s_tdata[PC_BITS];

    // History moves at acceptance; the branch carries its own global index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg  <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                history_reg <= idx_t'({history_reg, taken_in});
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_li_reg       <= li_in;
            p1_gi_reg       <= history_reg;
            p1_taken_reg    <= taken_in;
            byp_li_reg      <= p1_adv && (p1_li_reg == li_in);
            byp_gi_reg      <= p1_adv && (p1_gi_reg == history_reg);
            byp_local_reg   <= lc_new;
            byp_chooser_reg <= ch_new;
            byp_global_reg  <= gc_new;
        end
    end

    // Stage 1 compute
    always_comb begin
        lc     = byp_li_reg ? byp_local_reg   : local_rd_reg;
        ch     = byp_li_reg ? byp_chooser_reg : chooser_rd_reg;
        gc     = byp_gi_reg ? byp_global_reg  : global_rd_reg;
        lp     = lc[1];
        gp     = gc[1];
        pred   = ch[1] ? lp : gp;
        miss   = pred ^ p1_taken_reg;
        lc_new = sat_train(lc, p1_taken_reg);
        gc_new = sat_train(gc, p1_taken_reg);
        ch_new = (lp != gp) ? chooser_train(ch, lp == p1_taken_reg) : ch;
    end

    always_comb begin
        mem_we     = clr_active | p1_adv;
        wa_local   = clr_active ? clr_cnt_reg[IDX_BITS-1:0] : p1_li_reg;
        wa_global  = clr_active ? clr_cnt_reg[IDX_BITS-1:0] : p1_gi_reg;
        wd_local   = clr_active ? CTR_MIN : lc_new;
        wd_global  = clr_active ? CTR_MIN : gc_new;
        wd_chooser = clr_active ? CH_STRONG_GLOBAL : ch_new;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            local_mem[wa_local] <= wd_local;
        end
        if (s_accept) begin
            local_rd_reg <= local_mem[li_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            chooser_mem[wa_local] <= wd_chooser;
        end
        if (s_accept) begin
            chooser_rd_reg <= chooser_mem[li_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            global_mem[wa_global] <= wd_global;
        end
        if (s_accept) begin
            global_rd_reg <= global_mem[history_reg];
        end
    end

    // Totals count this branch
    assign branch_count_next = branch_count_reg + count_t'(1);
    assign miss_count_next   = miss_count_reg + count_t'(miss);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            branch_count_reg <= '0;
            miss_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (p1_adv) begin
                branch_count_reg <= branch_count_next;
                miss_count_reg   <= miss_count_next;
            end
            if (p1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            out_pred_reg <= pred;
            out_miss_reg <= miss;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, miss_count_reg, branch_count_reg, out_miss_reg, out_pred_reg};

endmodule

`default_nettype wire

FILE: verif/tbp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the tournament branch predictor: mirrors the local, global
// and chooser tables, predicts each result word and compares the DUT output.
// Depends on tbp_pkg.
module tbp_checker
    import tbp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,   // [31:0] branch_pc, [32] taken
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_DATA_BITS-1:0] m_tdata,   // [0] predicted_taken, [1] mispredicted,
                                                   // [33:2] branch_total, [65:34] miss_total
    output int                          err_count,
    output int                          pending
);

    typedef struct packed {
        logic   pred;
        logic   miss;
        count_t branches;
        count_t misses;
    } branch_result_t;

    ctr2_t          local_ctr   [IDX_ENTRIES];
    ctr2_t          global_ctr  [IDX_ENTRIES];
    ctr2_t          chooser_ctr [IDX_ENTRIES];
    idx_t           history;
    count_t         branch_cnt;
    count_t         miss_cnt;
    branch_result_t expected_results[$];
    int             mismatches = 0;

    function automatic ctr2_t saturate_step(input ctr2_t c, input logic up);
        if (up)
            return (c == CTR_MAX) ? c : c + 2'd1;
        return (c == CTR_MIN) ? c : c - 2'd1;
    endfunction

    // Predicts one branch and trains the mirrored tables.
    function automatic branch_result_t predict_branch(input logic [PC_BITS-1:0] pc,
                                                      input logic taken);
        idx_t           li;
        idx_t           gi;
        logic           lp;
        logic           gp;
        ctr2_t          sel;
        branch_result_t r;
        li  = pc[IDX_BITS+1:2];
        gi  = history;
        // counter predicts taken at 2 or 3
        lp  = local_ctr[li][1];
        gp  = global_ctr[gi][1];
        sel = chooser_ctr[li];
        r.pred = (sel == CH_WEAK_LOCAL || sel == CH_STRONG_LOCAL) ? lp : gp;
        r.miss = (r.pred != taken);

        local_ctr[li]  = saturate_step(local_ctr[li], taken);
        global_ctr[gi] = saturate_step(global_ctr[gi], taken);
        history        = idx_t'({gi, taken});

        // chooser jumps rather than counting: weak global goes straight to strong local
        if (lp != gp) begin
            if (lp == taken)
                chooser_ctr[li] = (sel == CH_STRONG_GLOBAL) ? CH_WEAK_GLOBAL : CH_STRONG_LOCAL;
            else
                chooser_ctr[li] = (sel == CH_STRONG_LOCAL) ? CH_WEAK_LOCAL : CH_STRONG_GLOBAL;
        end

        branch_cnt = branch_cnt + 1'b1;
        if (r.miss)
            miss_cnt = miss_cnt + 1'b1;
        r.branches = branch_cnt;
        r.misses   = miss_cnt;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, seen);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        branch_result_t want;
        branch_result_t seen;
        if (!aresetn) begin
            for (int i = 0; i < IDX_ENTRIES; i++) begin
                local_ctr[i]   = CTR_MIN;
                global_ctr[i]  = CTR_MIN;
                chooser_ctr[i] = CH_STRONG_GLOBAL;
            end
            history    = '0;
            branch_cnt = '0;
            miss_cnt   = '0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_branch(s_tdata[PC_BITS-1:0],
                                                          s_tdata[PC_BITS]));
            if (m_tvalid && m_tready) begin
                seen.pred     = m_tdata[0];
                seen.miss     = m_tdata[1];
                seen.branches = m_tdata[33:2];
                seen.misses   = m_tdata[65:34];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing expected: %0h",
                                 $realtime, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("predicted_taken", want.pred, seen.pred);
                    check_field("mispredicted", want.miss, seen.miss);
                    check_field("branch_total", want.branches, seen.branches);
                    check_field("miss_total", want.misses, seen.misses);
                end
            end
        end
        // NBA so the stimulus side always reads a settled value
        pending   <= expected_results.size();
        err_count <= mismatches;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Top of the tournament branch predictor testbench: clock, reset, branch
// stimulus, result-side backpressure and the verdict. Uses tbp_pkg and tbp_checker.
module tb;
    import tbp_pkg::*;

    localparam int STALL_LIMIT = 5000;   // covers the table clear after reset
    localparam int NUM_RANDOM  = 800;
    localparam int NUM_HOT     = 16;
    // low two bits and bits above the index: same table entry
    localparam logic [PC_BITS-1:0] ALIAS_MASK = ~(((PC_BITS)'(IDX_ENTRIES) - 1) << 2);

    typedef enum int {
        PAT_TAKEN,
        PAT_NOT_TAKEN,
        PAT_ALTERNATE,
        PAT_LOOP,
        PAT_RANDOM
    } pattern_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;   // [31:0] branch_pc, [32] taken
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;         // [0] predicted_taken, [1] mispredicted,
                                             // [33:2] branch_total, [65:34] miss_total
    logic                   no_idle  = 1'b0;
    int                     err_count;
    int                     pending;
    int                     stall_cycles = 0;

    logic [PC_BITS-1:0] hot_pc   [NUM_HOT];
    pattern_t           hot_kind [NUM_HOT];
    int                 hot_iter [NUM_HOT];

    tournament_branch_predictor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tbp_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .err_count (err_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= 28);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Holds one branch word until accepted; s_tvalid stays high between
    // back-to-back words.
    task automatic send_branch(input logic [PC_BITS-1:0] pc, input logic taken);
        if (!no_idle && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_BITS-PC_BITS-1){1'b0}}, taken, pc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int                 k;
        int                 roll;
        logic [PC_BITS-1:0] pc;
        logic               taken;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFC, 1'b0);
        send_branch(32'h0000_0003, 1'b1);   // low bits ignored: entry 0
        send_branch(32'h0000_1000, 1'b1);   // bit above the index: entry 0
        send_branch(32'h8000_0001, 1'b0);
        send_branch(32'h0000_0FFC, 1'b1);   // top entry
        // loop-like branch: saturates counters and pulls the chooser to local
        for (int i = 0; i < 4; i++) begin
            repeat (3) send_branch(32'h0000_0080, 1'b1);
            send_branch(32'h0000_0080, 1'b0);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        for (int i = 0; i < NUM_HOT; i++) begin
            hot_pc[i]   = $urandom;
            hot_kind[i] = pattern_t'($urandom_range(PAT_TAKEN, PAT_RANDOM));
            hot_iter[i] = 0;
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle <= (n >= 300 && n < 450);
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, NUM_HOT - 1);
            if (roll < 65) begin
                pc = hot_pc[k];
                case (hot_kind[k])
                    PAT_TAKEN:     taken = 1'b1;
                    PAT_NOT_TAKEN: taken = 1'b0;
                    PAT_ALTERNATE: taken = hot_iter[k][0];
                    PAT_LOOP:      taken = (hot_iter[k] % 7) != 6;
                    default:       taken = ($urandom_range(0, 99) < 80);
                endcase
                hot_iter[k]++;
            end else if (roll < 80) begin
                pc    = hot_pc[k] ^ ($urandom & ALIAS_MASK);
                taken = $urandom_range(0, 1);
            end else begin
                pc    = $urandom;
                taken = $urandom_range(0, 1);
            end
            send_branch(pc, taken);
        end

        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: tournament_branch_predictor.f
hw/rtl/tbp_pkg.sv
hw/rtl/tournament_branch_predictor.sv
verif/tbp_checker.sv
verif/tb.sv
